FILE: design/swbrm_pkg.sv
// Shared types and constants for the sliding window byte rate meter.
// No dependencies; compile first.
package swbrm_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 16;
    localparam int VALUE_W  = 64;
    localparam int WIN_W    = 6;
    localparam int BUCKET_W = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_PACKET = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_TOTAL  = 3'd2,
        KIND_RATE   = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

endpackage

FILE: design/swbrm_if.sv
// Valid/ready channel interfaces for the meter request and response beats.
// Depends on swbrm_pkg for field widths.
interface swbrm_in_if;
    logic                             valid;
    logic                             ready;
    logic [swbrm_pkg::KIND_W-1:0]     kind;
    logic [swbrm_pkg::BYTE_W-1:0]     byte_count;

    modport source (output valid, output kind, output byte_count, input ready);
    modport sink   (input valid, input kind, input byte_count, output ready);
endinterface

interface swbrm_out_if;
    logic                             valid;
    logic                             ready;
    logic [swbrm_pkg::VALUE_W-1:0]    value;
    logic                             is_rate;
    logic                             not_ready;

    modport source (output valid, output value, output is_rate, output not_ready, input ready);
    modport sink   (input valid, input value, input is_rate, input not_ready, output ready);
endinterface

FILE: design/sliding_window_byte_rate_meter.sv
// Sliding window byte rate meter built around one bucket memory.
// Depends on swbrm_pkg and the channel interfaces in swbrm_if.sv.
//
// Usage:
//   i_req carries request beats (kind, byte_count); o_rsp carries answers
//   (value, is_rate, not_ready) for total and rate queries only. The window
//   register is written through i_cfg_we / i_cfg_wdata; the user must write
//   it only while the block idles; the block itself does not enforce this.
// Steps per request; packet and tick are split by the single bucket write port:
//   packet (zero next bucket, then write back the saturated sum),
//   tick (zero two buckets), total query (accept, load output),
//   rate query (walk the ring buckets, run the bit-serial divider, load the
//   output; before a full window of ticks it loads a not_ready answer).
//   A clear, and reset, sweep the memory one bucket a cycle, during which no
//   request is taken (window writes still are).
// o_rsp is a registered output: a stalled answer holds while the next request
// is taken; a further answer waits until the held one is consumed.
module sliding_window_byte_rate_meter #(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swbrm_pkg::WIN_W-1:0]   i_cfg_wdata,
    swbrm_in_if.sink                      i_req,
    swbrm_out_if.source                   o_rsp
);

    localparam int SW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW  = $clog2(MAX_BUCKETS + 1);
    localparam int KW  = (CW > swbrm_pkg::WIN_W + 1) ? CW : swbrm_pkg::WIN_W + 1;
    localparam int BW  = swbrm_pkg::BUCKET_W;
    localparam int DW  = BW + CW;
    localparam int QCW = $clog2(DW + 1);
    localparam int VW  = swbrm_pkg::VALUE_W;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_PKT  = 7'b0000100,
        S_TICK = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state                       r_state, n_state;
    logic [swbrm_pkg::WIN_W-1:0]  r_win;
    logic [SW-1:0]                r_slot, n_slot;
    logic [swbrm_pkg::WIN_W-1:0]  r_sec, n_sec;
    logic [VW-1:0]                r_total, n_total;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_rd_pend, n_rd_pend;
    logic [SW-1:0]                r_wb_addr, n_wb_addr;
    logic [swbrm_pkg::BYTE_W-1:0] r_bytes, n_bytes;
    logic [KW-1:0]                r_ring, n_ring;
    logic [KW-1:0]                r_div, n_div;
    logic [DW-1:0]                r_sum, n_sum;
    logic [KW:0]                  r_rem, n_rem;
    logic [QCW-1:0]               r_dcnt, n_dcnt;
    logic [VW-1:0]                r_p_value, n_p_value;
    logic                         r_p_is_rate, n_p_is_rate;
    logic                         r_p_not_ready, n_p_not_ready;
    logic                         r_o_valid, n_o_valid;
    logic [VW-1:0]                r_o_value, n_o_value;
    logic                         r_o_is_rate, n_o_is_rate;
    logic                         r_o_not_ready, n_o_not_ready;

    logic [BW-1:0]                r_mem [MAX_BUCKETS];
    logic [BW-1:0]                r_rd_data;
    logic                         wr_en;
    logic [SW-1:0]                wr_addr;
    logic [BW-1:0]                wr_data;
    logic [SW-1:0]                rd_addr;

    logic [KW-1:0]                win_raw, eff_win, ring;
    logic [SW-1:0]                cur, nxt1, nxt2;
    logic                         in_rdy, acc;
    logic [BW:0]                  sat_add;
    logic [KW:0]                  shifted;
    logic                         qbit;

    function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] s,
                                                input logic [KW-1:0] rg);
        logic [KW-1:0] t;
        t = KW'(s) + KW'(1);
        return (t >= rg) ? '0 : t[SW-1:0];
    endfunction

    always_comb begin
        win_raw = KW'(r_win);
        if (win_raw == '0) begin
            eff_win = KW'(1);
        end else if (win_raw > KW'(MAX_BUCKETS - 1)) begin
            eff_win = KW'(MAX_BUCKETS - 1);
        end else begin
            eff_win = win_raw;
        end
        ring = eff_win + KW'(1);
        cur  = (KW'(r_slot) < ring) ? r_slot : '0;
        nxt1 = ring_next(cur, ring);
        nxt2 = ring_next(nxt1, ring);
    end

    assign in_rdy      = (r_state == S_IDLE);
    assign acc         = in_rdy && i_req.valid;
    assign i_req.ready = in_rdy;

    assign sat_add = {1'b0, r_rd_data} + (BW + 1)'(r_bytes);
    assign shifted = {r_rem[KW-1:0], r_sum[DW-1]};
    assign qbit    = (shifted >= {1'b0, r_div});

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_sec         = r_sec;
        n_total       = r_total;
        n_idx         = r_idx;
        n_rd_pend     = r_rd_pend;
        n_wb_addr     = r_wb_addr;
        n_bytes       = r_bytes;
        n_ring        = r_ring;
        n_div         = r_div;
        n_sum         = r_sum;
        n_rem         = r_rem;
        n_dcnt        = r_dcnt;
        n_p_value     = r_p_value;
        n_p_is_rate   = r_p_is_rate;
        n_p_not_ready = r_p_not_ready;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        n_o_value     = r_o_value;
        n_o_is_rate   = r_o_is_rate;
        n_o_not_ready = r_o_not_ready;
        wr_en         = 1'b0;
        wr_addr       = r_wb_addr;
        wr_data       = '0;
        rd_addr       = cur;

        case (r_state)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[SW-1:0];
                if (r_idx == CW'(MAX_BUCKETS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_IDLE: begin
                if (acc) begin
                    case (swbrm_pkg::t_kind'(i_req.kind))
                        swbrm_pkg::KIND_PACKET: begin
                            // zero the next bucket now, read the current one
                            wr_en     = 1'b1;
                            wr_addr   = nxt1;
                            n_wb_addr = cur;
                            n_bytes   = i_req.byte_count;
                            n_slot    = cur;
                            n_total   = r_total + VW'(i_req.byte_count);
                            n_state   = S_PKT;
                        end
                        swbrm_pkg::KIND_TICK: begin
                            wr_en     = 1'b1;
                            wr_addr   = nxt1;
                            n_wb_addr = nxt2;
                            n_slot    = nxt1;
                            if (KW'(r_sec) >= eff_win) begin
                                n_sec = eff_win[swbrm_pkg::WIN_W-1:0];
                            end else begin
                                n_sec = r_sec + swbrm_pkg::WIN_W'(1);
                            end
                            n_state = S_TICK;
                        end
                        swbrm_pkg::KIND_TOTAL: begin
                            n_p_value     = r_total;
                            n_p_is_rate   = 1'b0;
                            n_p_not_ready = 1'b0;
                            n_state       = S_EMIT;
                        end
                        swbrm_pkg::KIND_RATE: begin
                            n_p_is_rate = 1'b1;
                            if (KW'(r_sec) < eff_win) begin
                                n_p_value     = '0;
                                n_p_not_ready = 1'b1;
                                n_state       = S_EMIT;
                            end else begin
                                n_p_not_ready = 1'b0;
                                n_ring        = ring;
                                n_div         = eff_win;
                                n_idx         = '0;
                                n_rd_pend     = 1'b0;
                                n_sum         = '0;
                                n_state       = S_SUM;
                            end
                        end
                        swbrm_pkg::KIND_CLEAR: begin
                            n_slot  = '0;
                            n_sec   = '0;
                            n_total = '0;
                            n_idx   = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PKT: begin
                wr_en   = 1'b1;
                wr_data = sat_add[BW] ? '1 : sat_add[BW-1:0];
                n_state = S_IDLE;
            end
            S_TICK: begin
                wr_en   = 1'b1;
                n_state = S_IDLE;
            end
            S_SUM: begin
                // read data is registered, so it arrives the cycle after its address
                rd_addr = r_idx[SW-1:0];
                if (r_rd_pend) begin
                    n_sum = r_sum + DW'(r_rd_data);
                end
                if (KW'(r_idx) != r_ring) begin
                    n_idx     = r_idx + CW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    n_rem     = '0;
                    n_dcnt    = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = qbit ? (shifted - {1'b0, r_div}) : shifted;
                n_sum  = {r_sum[DW-2:0], qbit};
                n_dcnt = r_dcnt + QCW'(1);
                if (r_dcnt == QCW'(DW - 1)) begin
                    n_p_value = VW'({r_sum[DW-2:0], qbit});
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid     = 1'b1;
                    n_o_value     = r_p_value;
                    n_o_is_rate   = r_p_is_rate;
                    n_o_not_ready = r_p_not_ready;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_win     <= swbrm_pkg::WIN_RESET;
            r_slot    <= '0;
            r_sec     <= '0;
            r_total   <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            r_slot    <= n_slot;
            r_sec     <= n_sec;
            r_total   <= n_total;
            r_idx     <= n_idx;
            r_rd_pend <= n_rd_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr     <= n_wb_addr;
        r_bytes       <= n_bytes;
        r_ring        <= n_ring;
        r_div         <= n_div;
        r_sum         <= n_sum;
        r_rem         <= n_rem;
        r_dcnt        <= n_dcnt;
        r_p_value     <= n_p_value;
        r_p_is_rate   <= n_p_is_rate;
        r_p_not_ready <= n_p_not_ready;
        r_o_value     <= n_o_value;
        r_o_is_rate   <= n_o_is_rate;
        r_o_not_ready <= n_o_not_ready;
    end

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.value     = r_o_value;
    assign o_rsp.is_rate   = r_o_is_rate;
    assign o_rsp.not_ready = r_o_not_ready;

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.kind == swbrm_pkg::KIND_CLEAR) |=>
        (r_total == '0 && r_sec == '0 && r_state == S_CLR))
        else $error("clear did not zero total and second count");

    a_sweep_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (wr_en && wr_data == '0))
        else $error("clear sweep skipped a bucket");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divider running with zero divisor");

    a_not_ready_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_not_ready) |-> (r_o_is_rate && r_o_value == '0))
        else $error("not-ready answer carries a value");
`endif

endmodule

FILE: dv/swbrm_meter_checker.sv
// Checker for the sliding window byte rate meter: watches the request, response
// and window-write ports, predicts each answer and compares it field by field.
// Depends on swbrm_pkg and the channel interfaces in swbrm_if.sv.
module swbrm_meter_checker #(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swbrm_pkg::WIN_W-1:0] i_cfg_wdata,
    swbrm_in_if                         i_req,
    swbrm_out_if                        i_rsp,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct packed {
        logic [swbrm_pkg::VALUE_W-1:0] value;
        logic                          is_rate;
        logic                          not_ready;
    } t_answer;

    t_answer                         answer_q[$];
    logic [swbrm_pkg::BUCKET_W-1:0]  sec_bytes[MAX_BUCKETS];
    logic [swbrm_pkg::WIN_W-1:0]     window_reg;
    logic [swbrm_pkg::WIN_W-1:0]     slot;
    logic [swbrm_pkg::WIN_W-1:0]     secs_seen;
    logic [swbrm_pkg::VALUE_W-1:0]   byte_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Zero window means one second; anything past the store is clipped.
    function automatic int active_window();
        int w;
        w = int'(window_reg);
        if (w == 0) w = 1;
        if (w > MAX_BUCKETS - 1) w = MAX_BUCKETS - 1;
        return w;
    endfunction

    function automatic int ring_advance(input int s, input int ring);
        return (s + 1 >= ring) ? 0 : s + 1;
    endfunction

    task automatic wipe_meter();
        foreach (sec_bytes[i]) sec_bytes[i] = '0;
        slot       = '0;
        secs_seen  = '0;
        byte_total = '0;
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [swbrm_pkg::VALUE_W-1:0] got,
                                   input logic [swbrm_pkg::VALUE_W-1:0] want);
        if (o_fail_count < 40)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic meter_apply(input logic [swbrm_pkg::KIND_W-1:0] kind,
                               input logic [swbrm_pkg::BYTE_W-1:0] nbytes);
        int                             win;
        int                             ring;
        int                             cur;
        logic [swbrm_pkg::BUCKET_W:0]   sum_wide;
        logic [swbrm_pkg::VALUE_W-1:0]  window_sum;
        t_answer                        ans;
        win  = active_window();
        ring = win + 1;
        // a slot left outside a shrunk ring restarts at zero
        cur  = (int'(slot) < ring) ? int'(slot) : 0;
        case (kind)
            swbrm_pkg::KIND_PACKET: begin
                sum_wide = {1'b0, sec_bytes[cur]} + (swbrm_pkg::BUCKET_W + 1)'(nbytes);
                sec_bytes[cur] = sum_wide[swbrm_pkg::BUCKET_W] ?
                                 {swbrm_pkg::BUCKET_W{1'b1}} :
                                 sum_wide[swbrm_pkg::BUCKET_W-1:0];
                sec_bytes[ring_advance(cur, ring)] = '0;
                slot = (swbrm_pkg::WIN_W)'(cur);
                byte_total += (swbrm_pkg::VALUE_W)'(nbytes);
            end
            swbrm_pkg::KIND_TICK: begin
                cur = ring_advance(cur, ring);
                sec_bytes[cur] = '0;
                sec_bytes[ring_advance(cur, ring)] = '0;
                slot = (swbrm_pkg::WIN_W)'(cur);
                if (int'(secs_seen) >= win) secs_seen = (swbrm_pkg::WIN_W)'(win);
                else secs_seen = secs_seen + (swbrm_pkg::WIN_W)'(1);
            end
            swbrm_pkg::KIND_TOTAL: begin
                ans.value     = byte_total;
                ans.is_rate   = 1'b0;
                ans.not_ready = 1'b0;
                answer_q.push_back(ans);
            end
            swbrm_pkg::KIND_RATE: begin
                ans.is_rate = 1'b1;
                if (int'(secs_seen) < win) begin
                    ans.value     = '0;
                    ans.not_ready = 1'b1;
                end else begin
                    window_sum = '0;
                    for (int i = 0; i < ring; i++)
                        window_sum += (swbrm_pkg::VALUE_W)'(sec_bytes[i]);
                    ans.value     = window_sum / (swbrm_pkg::VALUE_W)'(win);
                    ans.not_ready = 1'b0;
                end
                answer_q.push_back(ans);
            end
            swbrm_pkg::KIND_CLEAR: wipe_meter();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            window_reg = swbrm_pkg::WIN_RESET;
            wipe_meter();
            answer_q.delete();
        end else begin
            // retire the answer first: it can never belong to a query taken this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("answer beat with nothing pending", i_rsp.value, '0);
                end else begin
                    want = answer_q.pop_front();
                    o_checked++;
                    if (i_rsp.value !== want.value)
                        report_mismatch("value", i_rsp.value, want.value);
                    if (i_rsp.is_rate !== want.is_rate)
                        report_mismatch("is_rate", (swbrm_pkg::VALUE_W)'(i_rsp.is_rate),
                                        (swbrm_pkg::VALUE_W)'(want.is_rate));
                    if (i_rsp.not_ready !== want.not_ready)
                        report_mismatch("not_ready", (swbrm_pkg::VALUE_W)'(i_rsp.not_ready),
                                        (swbrm_pkg::VALUE_W)'(want.not_ready));
                end
            end
            // a beat taken on the edge of a window write still sees the old window
            if (i_req.valid && i_req.ready) meter_apply(i_req.kind, i_req.byte_count);
            if (i_cfg_we) window_reg = i_cfg_wdata;
        end
        o_pending = answer_q.size();
    end

endmodule

FILE: dv/tb_sliding_window_byte_rate_meter.sv
// Top of the byte rate meter testbench: clock, reset, request and window-write
// stimulus, response back-pressure and the verdict.
// Depends on swbrm_pkg, swbrm_if.sv, the meter RTL and swbrm_meter_checker.
module tb_sliding_window_byte_rate_meter;

    localparam int NUM_BUCKETS  = 64;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASE_BEATS  = 40;
    localparam int FULL_PACKETS = 40;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [swbrm_pkg::WIN_W-1:0] cfg_wdata;

    swbrm_in_if  req_if();
    swbrm_out_if rsp_if();

    int  fail_count;
    int  pending;
    int  checked;
    int  cycle_count;
    int  beats_sent;
    int  windows_used;
    bit  gaps_on;
    bit  stalls_on;

    sliding_window_byte_rate_meter #(.MAX_BUCKETS(NUM_BUCKETS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    swbrm_meter_checker #(.MAX_BUCKETS(NUM_BUCKETS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers still pending", cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // response back-pressure in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Hold the beat until the meter takes it; valid stays high into the next beat.
    task automatic send_beat(input logic [swbrm_pkg::KIND_W-1:0] kind,
                             input logic [swbrm_pkg::BYTE_W-1:0] nbytes);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.byte_count <= nbytes;
        do @(posedge i_clk); while (!req_if.ready);
        beats_sent++;
    endtask

    // Drop valid, wait out every answer, then let clears and walks finish.
    task automatic drain_meter();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [swbrm_pkg::WIN_W-1:0] w);
        drain_meter();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        windows_used++;
    endtask

    function automatic logic [swbrm_pkg::BYTE_W-1:0] pick_bytes();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {swbrm_pkg::BYTE_W{1'b1}};
            2, 3:    return (swbrm_pkg::BYTE_W)'($urandom_range(0, 255));
            default: return (swbrm_pkg::BYTE_W)'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [swbrm_pkg::KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return swbrm_pkg::KIND_PACKET;
        if (r < 70) return swbrm_pkg::KIND_TICK;
        if (r < 78) return swbrm_pkg::KIND_TOTAL;
        if (r < 92) return swbrm_pkg::KIND_RATE;
        if (r < 95) return swbrm_pkg::KIND_CLEAR;
        return (swbrm_pkg::KIND_W)'($urandom_range(5, 7));
    endfunction

    task automatic run_phase(input logic [swbrm_pkg::WIN_W-1:0] w, input bit idle_ok);
        set_window(w);
        gaps_on   = idle_ok && ($urandom_range(0, 3) != 0);
        stalls_on = idle_ok && ($urandom_range(0, 3) != 0);
        // long windows need a full window of ticks before a rate is ready
        if (w > 7) begin
            for (int i = 0; i <= w; i++) begin
                send_beat(swbrm_pkg::KIND_TICK, pick_bytes());
                send_beat(swbrm_pkg::KIND_PACKET, pick_bytes());
            end
        end
        for (int i = 0; i < PHASE_BEATS; i++) send_beat(pick_kind(), pick_bytes());
    endtask

    initial begin
        logic [swbrm_pkg::WIN_W-1:0] phase_win[10];
        phase_win = '{6'd3, 6'd63, 6'd2, 6'd0, 6'd10, 6'd7, 6'd1, 6'd31,
                      (swbrm_pkg::WIN_W)'($urandom_range(1, 63)), 6'd5};
        cycle_count  = 0;
        beats_sent   = 0;
        windows_used = 0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_if.valid      <= 1'b0;
        req_if.kind       <= swbrm_pkg::KIND_PACKET;
        req_if.byte_count <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset window, extremes, ignored kinds, clear
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);
        send_beat(swbrm_pkg::KIND_TOTAL, 16'd0);
        send_beat(swbrm_pkg::KIND_PACKET, 16'hFFFF);
        send_beat(swbrm_pkg::KIND_PACKET, 16'h0000);
        send_beat(swbrm_pkg::KIND_PACKET, 16'h0001);
        send_beat(3'd5, 16'h5555);
        send_beat(3'd6, 16'hAAAA);
        send_beat(3'd7, 16'hFFFF);
        send_beat(swbrm_pkg::KIND_TOTAL, 16'd0);
        send_beat(swbrm_pkg::KIND_TICK, 16'd0);
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);
        send_beat(swbrm_pkg::KIND_CLEAR, 16'd0);
        send_beat(swbrm_pkg::KIND_TOTAL, 16'd0);
        set_window(6'd1);
        send_beat(swbrm_pkg::KIND_TICK, 16'd0);
        send_beat(swbrm_pkg::KIND_PACKET, 16'hFFFF);
        send_beat(swbrm_pkg::KIND_PACKET, 16'h8000);
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);
        send_beat(swbrm_pkg::KIND_TICK, 16'd0);
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);
        send_beat(swbrm_pkg::KIND_TOTAL, 16'd0);
        set_window(6'd0);
        send_beat(swbrm_pkg::KIND_TICK, 16'd0);
        send_beat(swbrm_pkg::KIND_PACKET, 16'h1234);
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);

        // pile a run of full-size packets into one bucket
        set_window(6'd1);
        send_beat(swbrm_pkg::KIND_CLEAR, 16'd0);
        send_beat(swbrm_pkg::KIND_TICK, 16'd0);
        for (int i = 0; i < FULL_PACKETS; i++) send_beat(swbrm_pkg::KIND_PACKET, 16'hFFFF);
        send_beat(swbrm_pkg::KIND_RATE, 16'd0);
        send_beat(swbrm_pkg::KIND_TOTAL, 16'd0);

        // random phases over several windows; the last runs without idling
        foreach (phase_win[p]) run_phase(phase_win[p], p != 9);

        drain_meter();
        $display("Covered %0d request beats over %0d window settings, %0d answers checked,",
                 beats_sent, windows_used, checked);
        $display("including runs of full-size packets and windows from zero up to the full ring.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
